>>> src/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared constants, types and helpers for the 32-bit stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package xxh_pkg;

  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  localparam int unsigned NumLanes = 4;

  // Four words of one chunk, word 0 in the low slot
  typedef logic [NumLanes-1:0][31:0] word_arr_t;

  // Control of one lane accumulator
  typedef struct packed {
    logic load;     // register word * PRIME2
    logic step;     // finish the round into the accumulator
    logic restart;  // fall back to the seed start value
  } lane_ctl_t;

  // Digest request from the top level
  typedef struct packed {
    logic        start;
    logic [31:0] h_init;  // converged lanes plus length
    logic [4:0]  tail_n;  // tail bytes still to mix, 0 to 15
  } dig_req_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Start value of each lane for a given seed
  function automatic logic [31:0] lane_init(input logic [31:0] seed, input logic [1:0] idx);
    logic [31:0] v;
    case (idx)
      2'd0:    v = seed + PRIME1 + PRIME2;
      2'd1:    v = seed + PRIME2;
      2'd2:    v = seed;
      default: v = seed - PRIME1;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/xxh_lane.sv
// ----------------------------------------------------------------------------
// xxh_lane
// One lane accumulator: each round chains two registered multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_lane (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xxh_pkg::lane_ctl_t ctl_i,
  input  wire logic [31:0]       word_i,
  input  wire logic [31:0]       init_i,
  output logic [31:0]            acc_o
);
  import xxh_pkg::*;

  logic [31:0] prod_q;
  logic [31:0] acc_q, acc_d;
  logic        fresh_q;

  // A fresh lane reads as its seed start value
  assign acc_o = fresh_q ? init_i : acc_q;

  // Second half of the round
  always_comb begin
    acc_d = rol32(acc_o + prod_q, 13) * PRIME1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      prod_q  <= '0;
      acc_q   <= '0;
    end else begin
      if (ctl_i.load) begin
        prod_q <= word_i * PRIME2;
      end
      if (ctl_i.restart) begin
        fresh_q <= 1'b1;
      end else if (ctl_i.step) begin
        acc_q   <= acc_d;
        fresh_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/xxh_digest.sv
// ----------------------------------------------------------------------------
// xxh_digest
// Merging stage: mixes the tail words and bytes, avalanches and holds the
// hash in an output register, using one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_digest (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire xxh_pkg::dig_req_t  req_i,
  input  wire xxh_pkg::word_arr_t words_i,
  output logic                    req_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             hash_value_o
);
  import xxh_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE, D_MUL1, D_MUL2, D_AV1, D_AV2, D_OUT
  } dstate_e;

  dstate_e     state_q;
  word_arr_t   chunk_q;
  logic [4:0]  n_q;
  logic [4:0]  pos_q;
  logic        word_step_q;
  logic [31:0] h_q;
  logic [31:0] m_q;
  logic [31:0] hash_q;
  logic        out_valid_q;

  logic [5:0]  pos_plus4;
  logic        word_fit;
  logic [31:0] cur_word;
  logic [7:0]  cur_byte;
  logic [4:0]  pos_next;
  logic [31:0] mix;
  logic [31:0] mul_a, mul_b, prod;

  assign req_ready_o  = (state_q == D_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  // Tail position and operand selection
  always_comb begin
    pos_plus4 = {1'b0, pos_q} + 6'd4;
    word_fit  = (pos_plus4 <= {1'b0, n_q});
    cur_word  = chunk_q[pos_q[3:2]];
    cur_byte  = 8'(cur_word >> {pos_q[1:0], 3'b000});
    pos_next  = pos_q + (word_step_q ? 5'd4 : 5'd1);
    mix       = h_q + m_q;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      D_MUL1: begin
        mul_a = word_fit ? cur_word : {24'd0, cur_byte};
        mul_b = word_fit ? PRIME3 : PRIME5;
      end
      D_MUL2: begin
        mul_a = word_step_q ? rol32(mix, 17) : rol32(mix, 11);
        mul_b = word_step_q ? PRIME4 : PRIME1;
      end
      D_AV1: begin
        mul_a = h_q ^ (h_q >> 15);
        mul_b = PRIME2;
      end
      D_AV2: begin
        mul_a = h_q ^ (h_q >> 13);
        mul_b = PRIME3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= D_IDLE;
      chunk_q     <= '0;
      n_q         <= '0;
      pos_q       <= '0;
      word_step_q <= 1'b0;
      h_q         <= '0;
      m_q         <= '0;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && (state_q != D_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            h_q     <= req_i.h_init;
            chunk_q <= words_i;
            n_q     <= req_i.tail_n;
            pos_q   <= '0;
            state_q <= (req_i.tail_n == 5'd0) ? D_AV1 : D_MUL1;
          end
        end
        D_MUL1: begin
          m_q         <= prod;
          word_step_q <= word_fit;
          state_q     <= D_MUL2;
        end
        D_MUL2: begin
          h_q     <= prod;
          pos_q   <= pos_next;
          state_q <= (pos_next < n_q) ? D_MUL1 : D_AV1;
        end
        D_AV1: begin
          h_q     <= prod;
          state_q <= D_AV2;
        end
        D_AV2: begin
          h_q     <= prod;
          state_q <= D_OUT;
        end
        D_OUT: begin
          // hold until the output slot is free
          if (!out_valid_q || out_ready_i) begin
            hash_q      <= h_q ^ (h_q >> 16);
            out_valid_q <= 1'b1;
            state_q     <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/xxh32_stream_hasher.sv
// Flow: a non-final beat passes through S_ROUND (one lane round, two chained
//   multiplies); no new chunk is taken until the block is back in S_IDLE.
// Final beat: a round if it is a full stripe, hand-over to the digest, a
//   multiply pair per tail word or byte, avalanche, load of the output.
// Next message chunks are taken while the digest and output run.
// Reset: seed 0, lanes at their seed start values, length and flags clear.
// ----------------------------------------------------------------------------
// xxh32_stream_hasher
// Four parallel lane accumulators with a sequential merging digest stage.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh32_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        seed_we_i,
  input  wire logic [31:0] seed_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] word_0_i,
  input  wire logic [31:0] word_1_i,
  input  wire logic [31:0] word_2_i,
  input  wire logic [31:0] word_3_i,
  input  wire logic [4:0]  byte_count_i,
  input  wire logic        final_chunk_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      hash_value_o
);
  import xxh_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_DIGEST} state_e;

  state_e      state_q;
  logic [31:0] seed_q;
  logic [31:0] length_q;
  logic        stripe_seen_q;
  logic        final_q;
  logic [4:0]  tail_n_q;
  word_arr_t   words_q;

  word_arr_t   words_in;
  word_arr_t   acc;
  lane_ctl_t   lane_ctl;
  dig_req_t    dig_req;
  logic        dig_ready;
  logic        accept;
  logic        full_chunk;
  logic        restart;
  logic [31:0] converge;

  assign words_in   = {word_3_i, word_2_i, word_1_i, word_0_i};
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // a final count above 16 saturates to a full chunk
  assign full_chunk = byte_count_i[4] || !final_chunk_i;

  // Lane control and digest request
  always_comb begin
    dig_req.start = (state_q == S_DIGEST) && dig_ready;
    restart       = dig_req.start || seed_we_i;
    lane_ctl.load    = accept;
    lane_ctl.step    = (state_q == S_ROUND);
    lane_ctl.restart = restart;
    // converge lanes (seed plus PRIME5 before any stripe) and add the length
    converge = stripe_seen_q
             ? rol32(acc[0], 1) + rol32(acc[1], 7) + rol32(acc[2], 12) + rol32(acc[3], 18)
             : seed_q + PRIME5;
    dig_req.h_init = converge + length_q;
    dig_req.tail_n = tail_n_q;
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    xxh_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .word_i (words_in[g]),
      .init_i (lane_init(seed_q, 2'(g))),
      .acc_o  (acc[g])
    );
  end

  xxh_digest u_digest (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (dig_req),
    .words_i      (words_q),
    .req_ready_o  (dig_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  // Control state, length and seed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      seed_q        <= '0;
      length_q      <= '0;
      stripe_seen_q <= 1'b0;
      final_q       <= 1'b0;
      tail_n_q      <= '0;
      words_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            words_q <= words_in;
            final_q <= final_chunk_i;
            if (full_chunk) begin
              length_q      <= length_q + 32'd16;
              stripe_seen_q <= 1'b1;
              tail_n_q      <= '0;
              state_q       <= S_ROUND;
            end else begin
              length_q <= length_q + {27'd0, byte_count_i};
              tail_n_q <= byte_count_i;
              state_q  <= S_DIGEST;
            end
          end
        end
        S_ROUND: begin
          state_q <= final_q ? S_DIGEST : S_IDLE;
        end
        S_DIGEST: begin
          // wait for the digest stage to take the message
          if (dig_ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (restart) begin
        length_q      <= '0;
        stripe_seen_q <= 1'b0;
      end
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> bench/xxh32_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh32_stream_hasher_tb
// Self-checking bench for the 32-bit stream hasher. A queue of chunk beats,
// directed first and then random messages, feeds a valid/ready driver. A
// predictor follows every accepted beat and stores the hash it expects. A
// monitor compares each hash beat with the oldest stored value. Phases change
// the seed and the amount of sender idling and receiver stalling.
// ----------------------------------------------------------------------------

module xxh32_stream_hasher_tb;

  localparam logic [31:0] K_PRIME1 = 32'd2654435761;
  localparam logic [31:0] K_PRIME2 = 32'd2246822519;
  localparam logic [31:0] K_PRIME3 = 32'd3266489917;
  localparam logic [31:0] K_PRIME4 = 32'd668265263;
  localparam logic [31:0] K_PRIME5 = 32'd374761393;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_CYCLES  = 50;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_BEATS   = 200;

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_e;

  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_e;

  typedef struct packed {
    logic [3:0][31:0] words;
    logic [4:0]       count;
    logic             last;
  } chunk_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        seed_we_i     = 1'b0;
  logic [31:0] seed_i        = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [31:0] word_0_i      = '0;
  logic [31:0] word_1_i      = '0;
  logic [31:0] word_2_i      = '0;
  logic [31:0] word_3_i      = '0;
  logic [4:0]  byte_count_i  = '0;
  logic        final_chunk_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [31:0] hash_value_o;

  xxh32_stream_hasher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_i       (seed_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_0_i     (word_0_i),
    .word_1_i     (word_1_i),
    .word_2_i     (word_2_i),
    .word_3_i     (word_3_i),
    .byte_count_i (byte_count_i),
    .final_chunk_i(final_chunk_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  // Bench state
  chunk_t      chunk_pending_q[$];
  logic [31:0] hash_expected_q[$];
  phase_e      phase        = PH_FREE;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned hashes_checked = 0;
  int unsigned seed_settings = 1;
  int unsigned fail_count   = 0;

  // Hasher image: seed, lanes, length and stripe flag
  logic [31:0] seed_now;
  logic [31:0] lane_sum[4];
  logic [31:0] msg_len;
  logic        saw_stripe;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    logic [63:0] d;
    d = {x, x};
    return d[63 - r -: 32];
  endfunction

  // Fall back to the seed start values and open a fresh message
  task automatic restart_message();
    lane_sum[0] = seed_now + K_PRIME1 + K_PRIME2;
    lane_sum[1] = seed_now + K_PRIME2;
    lane_sum[2] = seed_now;
    lane_sum[3] = seed_now - K_PRIME1;
    msg_len     = '0;
    saw_stripe  = 1'b0;
  endtask

  // One round on each lane
  task automatic absorb_stripe(input logic [3:0][31:0] w);
    logic [31:0] t;
    for (int i = 0; i < 4; i++) begin
      t           = lane_sum[i] + w[i] * K_PRIME2;
      lane_sum[i] = rotl32(t, 13) * K_PRIME1;
    end
    msg_len    = msg_len + 32'd16;
    saw_stripe = 1'b1;
  endtask

  // Follow one accepted beat; on the last one store the expected hash
  task automatic follow_chunk(input chunk_t c);
    int unsigned n;
    int unsigned pos;
    logic [31:0] h;
    logic [31:0] t;
    logic [31:0] b;
    if (!c.last) begin
      absorb_stripe(c.words);
      return;
    end
    n = (c.count > 5'd16) ? 16 : c.count;
    if (n == 16) begin
      absorb_stripe(c.words);
      n = 0;
    end else begin
      msg_len = msg_len + n;
    end
    if (saw_stripe) begin
      h = rotl32(lane_sum[0], 1) + rotl32(lane_sum[1], 7) +
          rotl32(lane_sum[2], 12) + rotl32(lane_sum[3], 18);
    end else begin
      h = seed_now + K_PRIME5;
    end
    h = h + msg_len;
    // Mix whole tail words, then single tail bytes
    pos = 0;
    while (pos + 4 <= n) begin
      t   = h + c.words[pos / 4] * K_PRIME3;
      h   = rotl32(t, 17) * K_PRIME4;
      pos = pos + 4;
    end
    while (pos < n) begin
      b   = {24'd0, c.words[pos / 4][8 * (pos % 4) +: 8]};
      t   = h + b * K_PRIME5;
      h   = rotl32(t, 11) * K_PRIME1;
      pos = pos + 1;
    end
    // Avalanche
    h = h ^ (h >> 15);
    h = h * K_PRIME2;
    h = h ^ (h >> 13);
    h = h * K_PRIME3;
    h = h ^ (h >> 16);
    hash_expected_q.push_back(h);
    restart_message();
  endtask

  task automatic queue_chunk(input logic [4:0] count, input logic last, input fill_e fill);
    chunk_t c;
    for (int i = 0; i < 4; i++) begin
      case (fill)
        FILL_ZERO: c.words[i] = '0;
        FILL_ONES: c.words[i] = '1;
        default:   c.words[i] = $urandom;
      endcase
    end
    c.count = count;
    c.last  = last;
    chunk_pending_q.push_back(c);
    beats_queued++;
  endtask

  // Mostly well-formed messages; some body beats carry a noisy count
  task automatic queue_message();
    int unsigned body;
    int unsigned r;
    fill_e       fill;
    r = $urandom_range(0, 99);
    if (r < 50) body = $urandom_range(0, 2);
    else if (r < 90) body = $urandom_range(3, 8);
    else body = $urandom_range(9, 24);
    for (int k = 0; k < body; k++) begin
      r    = $urandom_range(0, 99);
      fill = (r < 3) ? FILL_ZERO : (r < 6) ? FILL_ONES : FILL_RANDOM;
      if ($urandom_range(0, 9) == 0) queue_chunk(5'($urandom_range(0, 31)), 1'b0, fill);
      else queue_chunk(5'd16, 1'b0, fill);
    end
    r    = $urandom_range(0, 99);
    fill = (r < 3) ? FILL_ZERO : (r < 6) ? FILL_ONES : FILL_RANDOM;
    r    = $urandom_range(0, 99);
    if (r < 80) queue_chunk(5'($urandom_range(0, 16)), 1'b1, fill);
    else if (r < 90) queue_chunk(5'd16, 1'b1, fill);
    else queue_chunk(5'($urandom_range(17, 31)), 1'b1, fill);
  endtask

  // Wait until every beat is taken and every hash has come back
  task automatic wait_idle();
    while (chunk_pending_q.size() != 0 || in_valid_i || hash_expected_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(posedge clk_i);
    seed_we_i <= 1'b1;
    seed_i    <= value;
    @(posedge clk_i);
    seed_we_i <= 1'b0;
    seed_now = value;
    restart_message();
    seed_settings++;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input phase_e ph, input int unsigned src_pct,
                           input int unsigned snk_pct);
    int unsigned goal;
    phase         = ph;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    goal = beats_queued + PHASE_BEATS;
    while (beats_queued < goal) queue_message();
  endtask

  // Driver: present one beat at a time, hold it until taken
  always @(posedge clk_i) begin : drive_chunks
    chunk_t taken;
    chunk_t next_c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        taken.words = {word_3_i, word_2_i, word_1_i, word_0_i};
        taken.count = byte_count_i;
        taken.last  = final_chunk_i;
        follow_chunk(taken);
        beats_taken++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (chunk_pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_c = chunk_pending_q.pop_front();
          in_valid_i    <= 1'b1;
          word_0_i      <= next_c.words[0];
          word_1_i      <= next_c.words[1];
          word_2_i      <= next_c.words[2];
          word_3_i      <= next_c.words[3];
          byte_count_i  <= next_c.count;
          final_chunk_i <= next_c.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each hash beat, then pick the next ready level
  always @(posedge clk_i) begin : check_hashes
    int unsigned hold_left;
    bit          hold_done;
    logic [31:0] want;
    logic        rdy;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (hash_expected_q.size() == 0) begin
          $error("hash_value: expected none, actual %08h", hash_value_o);
          fail_count++;
        end else begin
          want = hash_expected_q.pop_front();
          hashes_checked++;
          if (hash_value_o !== want) begin
            $error("hash_value: expected %08h, actual %08h", want, hash_value_o);
            fail_count++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (phase == PH_PRESSURE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = ($urandom_range(0, 99) >= snk_stall_pct);
      end
      out_ready_i <= rdy;
    end
  end

  // Watchdog
  initial begin : watchdog
    for (int unsigned n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    seed_now = '0;
    restart_message();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset seed
    phase = PH_FREE;
    queue_chunk(5'd0, 1'b1, FILL_ZERO);           // empty message
    queue_chunk(5'd1, 1'b1, FILL_ONES);
    queue_chunk(5'd3, 1'b1, FILL_RANDOM);         // bytes only
    queue_chunk(5'd4, 1'b1, FILL_RANDOM);         // one tail word
    queue_chunk(5'd7, 1'b1, FILL_RANDOM);
    queue_chunk(5'd12, 1'b1, FILL_RANDOM);
    queue_chunk(5'd15, 1'b1, FILL_ONES);
    queue_chunk(5'd16, 1'b1, FILL_RANDOM);        // last beat as a full stripe
    queue_chunk(5'd17, 1'b1, FILL_RANDOM);        // oversized count
    queue_chunk(5'd31, 1'b1, FILL_ONES);
    queue_chunk(5'd16, 1'b0, FILL_ZERO);          // stripe, then empty tail
    queue_chunk(5'd0, 1'b1, FILL_RANDOM);
    queue_chunk(5'd5, 1'b0, FILL_RANDOM);         // short body beat
    queue_chunk(5'd9, 1'b1, FILL_RANDOM);
    queue_chunk(5'd16, 1'b0, FILL_ONES);
    queue_chunk(5'd0, 1'b0, FILL_RANDOM);
    queue_chunk(5'd16, 1'b1, FILL_RANDOM);
    queue_chunk(5'd31, 1'b0, FILL_RANDOM);
    queue_chunk(5'd13, 1'b1, FILL_RANDOM);        // unused bytes set
    // Leave a message open; the next seed write drops it
    queue_chunk(5'd16, 1'b0, FILL_RANDOM);
    queue_chunk(5'd16, 1'b0, FILL_ONES);
    queue_chunk(5'd2, 1'b0, FILL_RANDOM);
    wait_idle();

    write_seed(32'hFFFF_FFFF);
    run_phase(PH_FREE, 0, 0);
    wait_idle();

    write_seed($urandom);
    run_phase(PH_SRC_IDLE, 82, 0);
    wait_idle();

    write_seed(32'h8000_0001);
    run_phase(PH_SNK_STALL, 0, 82);
    wait_idle();

    write_seed(32'h0000_0000);
    run_phase(PH_BOTH, 20, 20);
    wait_idle();

    write_seed($urandom);
    run_phase(PH_PRESSURE, 0, 0);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (hash_expected_q.size() != 0) begin
      $error("hash_value: %0d expected hashes never arrived", hash_expected_q.size());
      fail_count++;
    end

    $display("Hashed %0d chunk beats into %0d checked digests under %0d seeds,",
             beats_taken, hashes_checked, seed_settings);
    $display("with free-running, idle-sender, stalled-receiver and back-pressure phases.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
